FILE: sv/set_assoc_cache_fifo_write_through_macros.svh
// Assertion macros for the cache checker
`ifndef SET_ASSOC_CACHE_FIFO_WRITE_THROUGH_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_WRITE_THROUGH_MACROS_SVH

`define SACF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

`define SACF_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

FILE: sv/sacf_pkg.sv
package sacf_pkg;
  localparam int NumSets   = 8;
  localparam int NumWays   = 4;
  localparam int LineBytes = 64;
  localparam int AddrBits  = 16;
  localparam int InWidth   = 32;
  localparam int OutWidth  = 80;

  typedef struct packed {
    logic start;
    logic out_taken;
  } sacf_cmd_t;

  typedef struct packed {
    logic clearing;
    logic lookup_done;
    logic need_fill;
    logic fill_done;
  } sacf_stat_t;
endpackage

FILE: sv/sacf_ram.sv
module sacf_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/sacf_ctrl.sv
module sacf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sacf_pkg::sacf_cmd_t  cmd,
  input  sacf_pkg::sacf_stat_t stat
);
  import sacf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // no item is taken while the backing store is being cleared
  assign in_ready  = (state == S_IDLE) && !stat.clearing;
  assign out_valid = (state == S_OUT);
  assign cmd.start     = in_valid && in_ready;
  assign cmd.out_taken = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.start) state_next = S_LOOK;
      S_LOOK: if (stat.lookup_done) state_next = stat.need_fill ? S_FILL : S_OUT;
      S_FILL: if (stat.fill_done) state_next = S_OUT;
      S_OUT:  if (cmd.out_taken) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

FILE: sv/sacf_dp.sv
module sacf_dp #(
  parameter int NUM_SETS   = sacf_pkg::NumSets,
  parameter int NUM_WAYS   = sacf_pkg::NumWays,
  parameter int LINE_BYTES = sacf_pkg::LineBytes,
  parameter int ADDR_BITS  = sacf_pkg::AddrBits
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sacf_pkg::sacf_cmd_t  cmd,
  output sacf_pkg::sacf_stat_t stat,
  input  logic                 operation,
  input  logic [ADDR_BITS-1:0] address,
  input  logic [7:0]           write_data,
  output logic [7:0]           read_data,
  output logic                 hit,
  output logic [31:0]          access_count,
  output logic [31:0]          miss_count
);
  import sacf_pkg::*;

  localparam int OffW  = $clog2(LINE_BYTES);
  localparam int SetW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SetB  = $clog2(NUM_SETS);
  localparam int WayW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TagW  = ADDR_BITS - OffW - SetB;
  localparam int Slots = NUM_SETS * NUM_WAYS;
  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int LineD = Slots * LINE_BYTES;
  localparam int LineW = $clog2(LineD);
  localparam int StoreD = 1 << ADDR_BITS;

  // latched request
  logic                 op;
  logic [ADDR_BITS-1:0] addr;
  logic [7:0]           wdat;
  logic                 phase;  // lookup: 0 = wait data, 1 = decide
  logic                 valid_look;  // a request sits in lookup
  logic                 fdone;

  logic [OffW-1:0] off;
  logic [SetW-1:0] set_idx;
  logic [TagW-1:0] tag;
  assign off = addr[OffW-1:0];
  if (NUM_SETS > 1) begin : g_set
    assign set_idx = addr[OffW +: SetB];
  end else begin : g_noset
    assign set_idx = '0;
  end
  assign tag = addr[ADDR_BITS-1 -: TagW];

  logic [TagW-1:0] tags [Slots];
  logic [Slots-1:0] valid;
  logic [WayW-1:0] fifo_ptr [NUM_SETS];

  logic            hit_c;
  logic [WayW-1:0] hit_way;
  logic            free_c;
  logic [WayW-1:0] free_way;
  logic [WayW-1:0] way;

  function automatic logic [SlotW-1:0] slot_of(logic [SetW-1:0] s, logic [WayW-1:0] w);
    return SlotW'(s * NUM_WAYS + w);
  endfunction

  always_comb begin
    hit_c = 1'b0;
    hit_way = '0;
    free_c = 1'b0;
    free_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (valid[slot_of(set_idx, WayW'(w))] &&
          tags[slot_of(set_idx, WayW'(w))] == tag) begin
        hit_c = 1'b1;
        hit_way = WayW'(w);
      end
      if (!valid[slot_of(set_idx, WayW'(w))]) begin
        free_c = 1'b1;
        free_way = WayW'(w);
      end
    end
  end

  // fill sequencing: byte counter, each byte read from the store in the cycle before its write
  logic            filling;
  logic [OffW:0]   fcnt;
  logic            fwr;
  logic [OffW-1:0] fwoff;
  logic [WayW-1:0] fway;

  // backing store: valid bit per address is too large, use a clear sweep
  logic                 clr_busy;
  logic [ADDR_BITS:0]   clr_cnt;
  logic                 st_we;
  logic [ADDR_BITS-1:0] st_waddr;
  logic [7:0]           st_wdata;
  logic [ADDR_BITS-1:0] st_raddr;
  logic [7:0]           st_rdata;

  assign st_raddr = {addr[ADDR_BITS-1:OffW], fcnt[OffW-1:0]};
  always_comb begin
    st_we = 1'b0;
    st_waddr = clr_cnt[ADDR_BITS-1:0];
    st_wdata = '0;
    if (clr_busy) begin
      st_we = 1'b1;
    end else if (cmd.start && operation) begin
      st_we = 1'b1;
      st_waddr = address;
      st_wdata = write_data;
    end
  end

  sacf_ram #(.Width(8), .Depth(StoreD)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  logic             ln_we;
  logic [LineW-1:0] ln_waddr;
  logic [7:0]       ln_wdata;
  logic [LineW-1:0] ln_raddr;
  logic [7:0]       ln_rdata;

  assign way = hit_c ? hit_way : (free_c ? free_way : fifo_ptr[set_idx]);
  assign ln_raddr = LineW'({slot_of(set_idx, way), off});
  always_comb begin
    ln_we = 1'b0;
    ln_waddr = LineW'({slot_of(set_idx, fway), fwoff});
    ln_wdata = st_rdata;
    if (fwr) begin
      ln_we = 1'b1;
    end else if (!phase && op && hit_c && !filling && cmd.start == 1'b0 && valid_look) begin
      ln_we = 1'b1;
      ln_waddr = LineW'({slot_of(set_idx, hit_way), off});
      ln_wdata = wdat;
    end
  end

  sacf_ram #(.Width(8), .Depth(LineD)) u_lines (
    .clk, .we(ln_we), .waddr(ln_waddr), .wdata(ln_wdata),
    .raddr(ln_raddr), .rdata(ln_rdata)
  );

  assign stat.clearing    = clr_busy;
  assign stat.lookup_done = valid_look && phase;
  assign stat.need_fill   = !op && !hit_c;
  assign stat.fill_done   = filling && !fwr && fcnt[OffW] && fwoff == '0 && fdone;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= operation;
      addr <= address;
      wdat <= write_data;
    end
    fwoff <= fcnt[OffW-1:0];
    if (valid_look && !phase) begin
      hit <= hit_c;
      fway <= way;
    end
    if (stat.lookup_done || stat.fill_done) begin
      read_data <= op ? 8'd0 : ln_rdata;
    end
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt <= '0;
      valid <= '0;
      for (int s = 0; s < NUM_SETS; s++) fifo_ptr[s] <= '0;
      access_count <= '0;
      miss_count <= '0;
      valid_look <= 1'b0;
      phase <= 1'b0;
      filling <= 1'b0;
      fcnt <= '0;
      fwr <= 1'b0;
      fdone <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == (ADDR_BITS+1)'(StoreD - 1)) clr_busy <= 1'b0;
      end
      // one-cycle pulse after the tag and pointer update
      fdone <= filling && fcnt[OffW] && !fwr && !fdone;
      if (cmd.start) begin
        valid_look <= 1'b1;
        phase <= 1'b0;
      end else if (valid_look && !phase) begin
        phase <= 1'b1;
        access_count <= access_count + 32'd1;
        if (!hit_c) miss_count <= miss_count + 32'd1;
      end else if (stat.lookup_done) begin
        valid_look <= 1'b0;
        if (stat.need_fill) begin
          filling <= 1'b1;
          fcnt <= '0;
        end
      end
      if (filling) begin
        fwr <= !fcnt[OffW];
        if (!fcnt[OffW]) begin
          fcnt <= fcnt + 1'b1;
        end else if (!fwr && !fdone) begin
          // last byte written; tag valid and pointer update, then re-read
          valid[slot_of(set_idx, fway)] <= 1'b1;
          tags[slot_of(set_idx, fway)] <= tag;
          fifo_ptr[set_idx] <= (fway == WayW'(NUM_WAYS - 1)) ? '0 : fway + 1'b1;
        end
        if (stat.fill_done) filling <= 1'b0;
      end
    end
  end
endmodule

FILE: sv/set_assoc_cache_fifo_write_through.sv
// Four-way set-associative byte cache, FIFO replacement, write-through.
// s_axis: one request item (operation, address, write_data); m_axis: one result
// (read_data, hit, access_count, miss_count) for every request, in order.
// One item at a time: s_axis_tready is high only when the block is idle.
// Hit or write: after acceptance the lookup waits for the line data, then decides,
// and m_axis_tvalid rises when the result register is loaded.
// Read miss: the 64-byte line is copied from the internal backing store one
// byte per cycle, then tags and FIFO pointer update and the byte is re-read.
// After reset a clearing pass zeroes the backing store one byte per cycle;
// s_axis_tready stays low until the pass has finished.
// A stalled m_axis holds its result; no new item is taken meanwhile, so a
// stall lengthens the item.
module set_assoc_cache_fifo_write_through #(
  parameter int NUM_SETS   = sacf_pkg::NumSets,
  parameter int NUM_WAYS   = sacf_pkg::NumWays,
  parameter int LINE_BYTES = sacf_pkg::LineBytes,
  parameter int ADDR_BITS  = sacf_pkg::AddrBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation, address, write_data, zero pad
  input  logic [sacf_pkg::InWidth-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data, hit, access_count, miss_count, pad
  output logic [sacf_pkg::OutWidth-1:0] m_axis_tdata
);
  import sacf_pkg::*;

  sacf_cmd_t  cmd;
  sacf_stat_t stat;
  logic        in_ready_c;
  logic [7:0]  read_data;
  logic        hit;
  logic [31:0] access_count;
  logic [31:0] miss_count;

  sacf_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(in_ready_c),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .cmd, .stat
  );
  assign s_axis_tready = in_ready_c;

  sacf_dp #(
    .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
    .LINE_BYTES(LINE_BYTES), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk, .rst, .cmd, .stat,
    .operation(s_axis_tdata[0]),
    .address(s_axis_tdata[ADDR_BITS:1]),
    .write_data(s_axis_tdata[ADDR_BITS+8:ADDR_BITS+1]),
    .read_data, .hit, .access_count, .miss_count
  );

  assign m_axis_tdata = {7'd0, miss_count, access_count, hit, read_data};
endmodule

FILE: sv/sacf_checker.sv
module sacf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [79:0] m_axis_tdata
);
`include "set_assoc_cache_fifo_write_through_macros.svh"
  `SACF_ASSERT_IMP(a_excl, clk, rst, m_axis_tvalid, !s_axis_tready)
  `SACF_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SACF_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SACF_ASSERT_IMP(a_miss, clk, rst, m_axis_tvalid, m_axis_tdata[72:41] <= m_axis_tdata[40:9])
endmodule

bind set_assoc_cache_fifo_write_through sacf_checker u_chk (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
